// ===== src/imucf_pkg.sv =====
`timescale 1ns / 1ps

package imucf_pkg;

    localparam int ZW    = 34;
    localparam int XW    = 44;
    localparam int CW    = 32;
    localparam int MW    = 34;
    localparam int STEPS = 24;
    localparam int SW    = 5;

    localparam logic signed [ZW-1:0] DEG180   = 34'sd3019898880;
    localparam logic signed [ZW-1:0] DEG90    = 34'sd1509949440;
    localparam logic signed [XW-1:0] INV_GAIN = 44'sd652032874;

    typedef enum logic
    {
        CORDIC_VECTOR,
        CORDIC_ROTATE
    } cordic_mode_t;

    typedef struct packed
    {
        logic         start;
        cordic_mode_t mode;
    } cordic_req_t;

    function automatic logic signed [ZW-1:0] atan_q24(input logic [SW-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 34'sd754974720;
            5'd1:    v = 34'sd445687602;
            5'd2:    v = 34'sd235489089;
            5'd3:    v = 34'sd119537938;
            5'd4:    v = 34'sd60000934;
            5'd5:    v = 34'sd30029717;
            5'd6:    v = 34'sd15018523;
            5'd7:    v = 34'sd7509719;
            5'd8:    v = 34'sd3754917;
            5'd9:    v = 34'sd1877466;
            5'd10:   v = 34'sd938734;
            5'd11:   v = 34'sd469367;
            5'd12:   v = 34'sd234684;
            5'd13:   v = 34'sd117342;
            5'd14:   v = 34'sd58671;
            5'd15:   v = 34'sd29335;
            5'd16:   v = 34'sd14668;
            5'd17:   v = 34'sd7334;
            5'd18:   v = 34'sd3667;
            5'd19:   v = 34'sd1833;
            5'd20:   v = 34'sd917;
            5'd21:   v = 34'sd458;
            5'd22:   v = 34'sd229;
            5'd23:   v = 34'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/imucf_cordic.sv =====
`timescale 1ns / 1ps

module imucf_cordic
    import imucf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cordic_req_t          req,
    input  logic signed [ZW-1:0] in_x,
    input  logic signed [ZW-1:0] in_y,
    input  logic signed [ZW-1:0] in_z,
    output logic                 done,
    output logic signed [CW-1:0] res_x,
    output logic signed [CW-1:0] res_y,
    output logic signed [ZW-1:0] res_z
);

    typedef enum logic [1:0]
    {
        C_IDLE,
        C_NORM,
        C_ITER
    } cstate_t;

    localparam logic [XW-1:0] M31 = XW'(1) << 31;
    localparam logic [XW-1:0] M39 = XW'(1) << 39;

    cstate_t              state_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [SW-1:0]        i_reg;
    logic                 neg_reg;
    cordic_mode_t         mode_reg;
    logic                 done_reg;

    logic signed [XW-1:0] ext_x;
    logic signed [XW-1:0] ext_y;
    logic [XW-1:0]        abs_x;
    logic [XW-1:0]        abs_y;
    logic [XW-1:0]        mag;
    logic signed [XW-1:0] sh_x;
    logic signed [XW-1:0] sh_y;
    logic signed [ZW-1:0] tval;
    logic signed [XW-1:0] out_x;
    logic signed [XW-1:0] out_y;
    logic                 zero_c;
    logic                 last_c;

    assign ext_x  = {{(XW-ZW){in_x[ZW-1]}}, in_x};
    assign ext_y  = {{(XW-ZW){in_y[ZW-1]}}, in_y};
    assign abs_x  = x_reg[XW-1] ? XW'(-x_reg) : XW'(x_reg);
    assign abs_y  = y_reg[XW-1] ? XW'(-y_reg) : XW'(y_reg);
    assign mag    = (abs_x > abs_y) ? abs_x : abs_y;
    assign sh_x   = x_reg >>> i_reg;
    assign sh_y   = y_reg >>> i_reg;
    assign tval   = atan_q24(i_reg);
    assign out_x  = neg_reg ? -x_reg : x_reg;
    assign out_y  = neg_reg ? -y_reg : y_reg;
    assign zero_c = req.start && (req.mode == CORDIC_VECTOR) && (in_x == '0) && (in_y == '0);
    assign last_c = (i_reg == SW'(STEPS - 1));

    assign done  = done_reg;
    assign res_x = out_x[CW-1:0];
    assign res_y = out_y[CW-1:0];
    assign res_z = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= ((state_reg == C_IDLE) && zero_c) || ((state_reg == C_ITER) && last_c);
            case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        mode_reg <= req.mode;
                        i_reg    <= '0;
                        if (req.mode == CORDIC_VECTOR)
                        begin
                            neg_reg <= 1'b0;
                            if (in_x == '0 && in_y == '0)
                            begin
                                z_reg <= '0;
                            end
                            else if (in_x[ZW-1])
                            begin
                                z_reg     <= in_y[ZW-1] ? -DEG180 : DEG180;
                                x_reg     <= -ext_x;
                                y_reg     <= -ext_y;
                                state_reg <= C_NORM;
                            end
                            else
                            begin
                                z_reg     <= '0;
                                x_reg     <= ext_x;
                                y_reg     <= ext_y;
                                state_reg <= C_NORM;
                            end
                        end
                        else
                        begin
                            x_reg <= INV_GAIN;
                            y_reg <= '0;
                            if (in_z > DEG90)
                            begin
                                z_reg   <= in_z - DEG180;
                                neg_reg <= 1'b1;
                            end
                            else if (in_z < -DEG90)
                            begin
                                z_reg   <= in_z + DEG180;
                                neg_reg <= 1'b1;
                            end
                            else
                            begin
                                z_reg   <= in_z;
                                neg_reg <= 1'b0;
                            end
                            state_reg <= C_ITER;
                        end
                    end
                end
                C_NORM:
                begin
                    if (mag < M31)
                    begin
                        x_reg <= x_reg <<< 8;
                        y_reg <= y_reg <<< 8;
                    end
                    else if (mag < M39)
                    begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end
                    else
                    begin
                        state_reg <= C_ITER;
                    end
                end
                C_ITER:
                begin
                    if (mode_reg == CORDIC_VECTOR)
                    begin
                        if (!y_reg[XW-1])
                        begin
                            x_reg <= x_reg + sh_y;
                            y_reg <= y_reg - sh_x;
                            z_reg <= z_reg + tval;
                        end
                        else
                        begin
                            x_reg <= x_reg - sh_y;
                            y_reg <= y_reg + sh_x;
                            z_reg <= z_reg - tval;
                        end
                    end
                    else
                    begin
                        if (!z_reg[ZW-1])
                        begin
                            x_reg <= x_reg - sh_y;
                            y_reg <= y_reg + sh_x;
                            z_reg <= z_reg - tval;
                        end
                        else
                        begin
                            x_reg <= x_reg + sh_y;
                            y_reg <= y_reg - sh_x;
                            z_reg <= z_reg + tval;
                        end
                    end
                    if (last_c)
                    begin
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/imu_complementary_attitude_filter_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         tvalid / tready    tdata: accel x,y,z, gyro x,y,z, mag x,y,z; tuser: flags
// m_        out        tvalid / tready    tdata: roll, pitch, yaw (Q15.16 degrees)
// apb       in         psel/penable/pready  six registers at byte address 4*i
//
// The time one sample takes is set by the shared CORDIC unit (three vectoring passes of
// 24 iterations plus scaling, two rotation passes), the 25-step square root and three
// reciprocal-multiply quotients on the shared multiplier; a zero vector skips its
// vectoring pass and finishes sooner.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register and the next sample is taken meanwhile; the next result stalls until then.
// Reset clears angles, held magnetometer values and loads register defaults.

module imu_complementary_attitude_filter_core
    import imucf_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // accel_x/y/z, gyro_x/y/z, mag_x/y/z
    input  logic [1:0]   s_tuser,  // mag_ready, mag_overflow
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // roll_deg, pitch_deg, yaw_deg
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int QB     = ANGLE_FRAC_BITS + 5;
    localparam int ACC_SH = 24 - ANGLE_FRAC_BITS;
    localparam int PW     = 2 * MW;
    localparam int SQW    = 50;

    localparam logic [31:0]           DIV_D   = 32'd131000000;
    localparam longint unsigned       RECIP_L = (64'd1 << (ANGLE_FRAC_BITS + 31)) / 64'd131000000;
    localparam logic [MW-1:0]         RECIP   = MW'(RECIP_L);
    localparam logic [30:0]           YAW_MIN = 31'd131000;

    localparam logic [2:0] REG_ALPHA = 3'd0;
    localparam logic [2:0] REG_STEP  = 3'd1;
    localparam logic [2:0] REG_ZOFF  = 3'd2;
    localparam logic [2:0] REG_ASA_X = 3'd3;
    localparam logic [2:0] REG_ASA_Y = 3'd4;
    localparam logic [2:0] REG_ASA_Z = 3'd5;

    localparam logic [1:0] AX_ROLL  = 2'd0;
    localparam logic [1:0] AX_PITCH = 2'd1;
    localparam logic [1:0] AX_YAW   = 2'd2;

    typedef enum logic [5:0]
    {
        S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_SQRT,
        S_ROLL_GO, S_ROLL_WT, S_PITCH_GO, S_PITCH_WT,
        S_SCR_GO, S_SCR_WT, S_SCP_GO, S_SCP_WT,
        S_HX, S_HY, S_HZ, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7,
        S_HEAD_GO, S_HEAD_WT, S_G0, S_G1, S_Q0, S_Q1, S_Q2, S_Q3,
        S_B0, S_B1, S_B2, S_DONE
    } state_t;

    state_t state_reg;

    logic [15:0]        alpha_reg;
    logic [15:0]        step_reg;
    logic signed [15:0] zoff_reg;
    logic [7:0]         asa_x_reg;
    logic [7:0]         asa_y_reg;
    logic [7:0]         asa_z_reg;

    logic signed [15:0] ax_reg;
    logic signed [15:0] ay_reg;
    logic signed [16:0] az_reg;
    logic signed [15:0] gx_reg;
    logic signed [15:0] gy_reg;
    logic signed [15:0] gz_reg;
    logic signed [15:0] held_x_reg;
    logic signed [15:0] held_y_reg;
    logic signed [15:0] held_z_reg;
    logic signed [31:0] roll_reg;
    logic signed [31:0] pitch_reg;
    logic signed [31:0] yaw_reg;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] t_reg;
    logic [SQW-1:0]       sq_v_reg;
    logic [SQW-1:0]       sq_r_reg;
    logic [4:0]           sq_cnt_reg;
    logic signed [ZW-1:0] roll_a_reg;
    logic signed [ZW-1:0] pitch_a_reg;
    logic signed [ZW-1:0] head_a_reg;
    logic signed [CW-1:0] cr_reg;
    logic signed [CW-1:0] sr_reg;
    logic signed [CW-1:0] cp_reg;
    logic signed [CW-1:0] sp_reg;
    logic signed [24:0]   hx_reg;
    logic signed [24:0]   hy_reg;
    logic signed [24:0]   hz_reg;
    logic signed [31:0]   myp_reg;
    logic signed [31:0]   mzp_reg;
    logic signed [32:0]   mhx_reg;
    logic [1:0]           axis_reg;
    logic                 skip_reg;
    logic [30:0]          pabs_reg;
    logic [QB-1:0]        div_q_reg;
    logic                 div_neg_reg;
    logic                 m_tvalid_reg;
    logic [95:0]          m_tdata_reg;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [15:0]   g_sel;
    logic signed [31:0]   prev_sel;
    logic signed [ZW-1:0] acc_sel;
    logic signed [MW-1:0] q_c;
    logic signed [MW-1:0] inc_c;
    logic signed [MW-1:0] gp_c;
    logic signed [PW-1:0] sum_c;
    logic signed [PW-1:0] diff_c;
    logic signed [PW-1:0] blend_c;
    logic signed [31:0]   sat_c;
    logic [PW-1:0]        pabs_c;
    logic [PW-1:0]        rem_c;
    logic [SQW-1:0]       sq_bit_c;
    logic [SQW-1:0]       sq_rb_c;
    logic                 out_load_c;
    logic                 cfg_wr;

    cordic_req_t          cor_req;
    logic signed [ZW-1:0] cor_x;
    logic signed [ZW-1:0] cor_y;
    logic signed [ZW-1:0] cor_z;
    logic                 cor_done;
    logic signed [CW-1:0] cor_res_x;
    logic signed [CW-1:0] cor_res_y;
    logic signed [ZW-1:0] cor_res_z;

    imucf_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .in_x  (cor_x),
        .in_y  (cor_y),
        .in_z  (cor_z),
        .done  (cor_done),
        .res_x (cor_res_x),
        .res_y (cor_res_y),
        .res_z (cor_res_z)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[4:2])
            REG_ALPHA: prdata = {16'h0000, alpha_reg};
            REG_STEP:  prdata = {16'h0000, step_reg};
            REG_ZOFF:  prdata = {{16{zoff_reg[15]}}, zoff_reg};
            REG_ASA_X: prdata = {24'h000000, asa_x_reg};
            REG_ASA_Y: prdata = {24'h000000, asa_y_reg};
            REG_ASA_Z: prdata = {24'h000000, asa_z_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 16'd64225;
            step_reg  <= 16'd1000;
            zoff_reg  <= 16'sd7000;
            asa_x_reg <= 8'd128;
            asa_y_reg <= 8'd128;
            asa_z_reg <= 8'd128;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_ALPHA: alpha_reg <= pwdata[15:0];
                REG_STEP:  step_reg  <= pwdata[15:0];
                REG_ZOFF:  zoff_reg  <= pwdata[15:0];
                REG_ASA_X: asa_x_reg <= pwdata[7:0];
                REG_ASA_Y: asa_y_reg <= pwdata[7:0];
                REG_ASA_Z: asa_z_reg <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (axis_reg)
            AX_ROLL:
            begin
                g_sel    = gx_reg;
                prev_sel = roll_reg;
                acc_sel  = roll_a_reg >>> ACC_SH;
            end
            AX_PITCH:
            begin
                g_sel    = gy_reg;
                prev_sel = pitch_reg;
                acc_sel  = pitch_a_reg >>> ACC_SH;
            end
            default:
            begin
                g_sel    = gz_reg;
                prev_sel = yaw_reg;
                acc_sel  = head_a_reg >>> ACC_SH;
            end
        endcase
    end

    assign q_c        = signed'(MW'(div_q_reg));
    assign inc_c      = div_neg_reg ? -q_c : q_c;
    assign gp_c       = MW'(prev_sel) + inc_c;
    assign sum_c      = t_reg + prod_reg;
    assign diff_c     = t_reg - prod_reg;
    assign blend_c    = sum_c >>> 16;
    assign sat_c      = ((&blend_c[PW-1:31]) || !(|blend_c[PW-1:31])) ? blend_c[31:0]
                      : (blend_c[PW-1] ? 32'sh80000000 : 32'sh7fffffff);
    assign pabs_c     = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign rem_c      = (PW'(pabs_reg) << ANGLE_FRAC_BITS) - PW'(prod_reg);
    assign sq_bit_c   = SQW'(1) << {sq_cnt_reg, 1'b0};
    assign sq_rb_c    = sq_r_reg + sq_bit_c;
    assign out_load_c = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ0:
            begin
                mul_a = MW'(ay_reg);
                mul_b = MW'(ay_reg);
            end
            S_SQ1:
            begin
                mul_a = MW'(az_reg);
                mul_b = MW'(az_reg);
            end
            S_HX:
            begin
                mul_a = MW'(held_x_reg);
                mul_b = MW'({1'b0, asa_x_reg} + 9'd128);
            end
            S_HY:
            begin
                mul_a = MW'(held_y_reg);
                mul_b = MW'({1'b0, asa_y_reg} + 9'd128);
            end
            S_HZ:
            begin
                mul_a = MW'(held_z_reg);
                mul_b = MW'({1'b0, asa_z_reg} + 9'd128);
            end
            S_M1:
            begin
                mul_a = MW'(hy_reg);
                mul_b = MW'(cr_reg);
            end
            S_M2:
            begin
                mul_a = MW'(hz_reg);
                mul_b = MW'(sr_reg);
            end
            S_M3:
            begin
                mul_a = MW'(hz_reg);
                mul_b = MW'(cr_reg);
            end
            S_M4:
            begin
                mul_a = MW'(hy_reg);
                mul_b = MW'(sr_reg);
            end
            S_M5:
            begin
                mul_a = MW'(hx_reg) <<< 6;
                mul_b = MW'(cp_reg);
            end
            S_M6:
            begin
                mul_a = MW'(mzp_reg);
                mul_b = MW'(sp_reg);
            end
            S_G0:
            begin
                mul_a = MW'(g_sel);
                mul_b = MW'(step_reg);
            end
            S_Q0:
            begin
                mul_a = MW'(pabs_reg);
                mul_b = RECIP;
            end
            S_Q2:
            begin
                mul_a = MW'(div_q_reg);
                mul_b = MW'(DIV_D);
            end
            S_B0:
            begin
                mul_a = MW'(alpha_reg);
                mul_b = gp_c;
            end
            S_B1:
            begin
                mul_a = MW'(17'h10000 - {1'b0, alpha_reg});
                mul_b = MW'(acc_sel);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        cor_req.start = 1'b0;
        cor_req.mode  = CORDIC_VECTOR;
        cor_x         = '0;
        cor_y         = '0;
        cor_z         = '0;
        case (state_reg)
            S_ROLL_GO:
            begin
                cor_req.start = 1'b1;
                cor_x         = ZW'(az_reg);
                cor_y         = ZW'(ay_reg);
            end
            S_PITCH_GO:
            begin
                cor_req.start = 1'b1;
                cor_x         = signed'(ZW'(sq_r_reg[24:0]));
                cor_y         = -(ZW'(ax_reg) <<< 8);
            end
            S_SCR_GO:
            begin
                cor_req.start = 1'b1;
                cor_req.mode  = CORDIC_ROTATE;
                cor_z         = roll_a_reg;
            end
            S_SCP_GO:
            begin
                cor_req.start = 1'b1;
                cor_req.mode  = CORDIC_ROTATE;
                cor_z         = pitch_a_reg;
            end
            S_HEAD_GO:
            begin
                cor_req.start = 1'b1;
                cor_x         = ZW'(mhx_reg);
                cor_y         = -ZW'(myp_reg);
            end
            default:
            begin
                cor_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            held_x_reg   <= '0;
            held_y_reg   <= '0;
            held_z_reg   <= '0;
            roll_reg     <= '0;
            pitch_reg    <= '0;
            yaw_reg      <= '0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;
            if (out_load_c)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        ax_reg <= s_tdata[15:0];
                        ay_reg <= s_tdata[31:16];
                        az_reg <= {s_tdata[47], s_tdata[47:32]} - {zoff_reg[15], zoff_reg};
                        gx_reg <= s_tdata[63:48];
                        gy_reg <= s_tdata[79:64];
                        gz_reg <= s_tdata[95:80];
                        if (s_tuser[0] && !s_tuser[1])
                        begin
                            held_x_reg <= s_tdata[111:96];
                            held_y_reg <= s_tdata[127:112];
                            held_z_reg <= s_tdata[143:128];
                        end
                        state_reg <= S_SQ0;
                    end
                end
                S_SQ0:
                begin
                    state_reg <= S_SQ1;
                end
                S_SQ1:
                begin
                    t_reg     <= prod_reg;
                    state_reg <= S_SQ2;
                end
                S_SQ2:
                begin
                    sq_v_reg   <= SQW'(sum_c[33:0]) << 16;
                    sq_r_reg   <= '0;
                    sq_cnt_reg <= 5'd24;
                    state_reg  <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (sq_v_reg >= sq_rb_c)
                    begin
                        sq_v_reg <= sq_v_reg - sq_rb_c;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_c;
                    end
                    else
                    begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    if (sq_cnt_reg == '0)
                    begin
                        state_reg <= S_ROLL_GO;
                    end
                    else
                    begin
                        sq_cnt_reg <= sq_cnt_reg - 1'b1;
                    end
                end
                S_ROLL_GO:
                begin
                    state_reg <= S_ROLL_WT;
                end
                S_ROLL_WT:
                begin
                    if (cor_done)
                    begin
                        roll_a_reg <= cor_res_z;
                        state_reg  <= S_PITCH_GO;
                    end
                end
                S_PITCH_GO:
                begin
                    state_reg <= S_PITCH_WT;
                end
                S_PITCH_WT:
                begin
                    if (cor_done)
                    begin
                        pitch_a_reg <= cor_res_z;
                        state_reg   <= S_SCR_GO;
                    end
                end
                S_SCR_GO:
                begin
                    state_reg <= S_SCR_WT;
                end
                S_SCR_WT:
                begin
                    if (cor_done)
                    begin
                        cr_reg    <= cor_res_x;
                        sr_reg    <= cor_res_y;
                        state_reg <= S_SCP_GO;
                    end
                end
                S_SCP_GO:
                begin
                    state_reg <= S_SCP_WT;
                end
                S_SCP_WT:
                begin
                    if (cor_done)
                    begin
                        cp_reg    <= cor_res_x;
                        sp_reg    <= cor_res_y;
                        state_reg <= S_HX;
                    end
                end
                S_HX:
                begin
                    state_reg <= S_HY;
                end
                S_HY:
                begin
                    hx_reg    <= prod_reg[24:0];
                    state_reg <= S_HZ;
                end
                S_HZ:
                begin
                    hy_reg    <= prod_reg[24:0];
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    hz_reg    <= prod_reg[24:0];
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    t_reg     <= prod_reg;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    myp_reg   <= 32'(sum_c >>> 24);
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    t_reg     <= prod_reg;
                    state_reg <= S_M5;
                end
                S_M5:
                begin
                    mzp_reg   <= 32'(diff_c >>> 24);
                    state_reg <= S_M6;
                end
                S_M6:
                begin
                    t_reg     <= prod_reg >>> 30;
                    state_reg <= S_M7;
                end
                S_M7:
                begin
                    mhx_reg   <= 33'(t_reg - (prod_reg >>> 30));
                    state_reg <= S_HEAD_GO;
                end
                S_HEAD_GO:
                begin
                    state_reg <= S_HEAD_WT;
                end
                S_HEAD_WT:
                begin
                    if (cor_done)
                    begin
                        head_a_reg <= cor_res_z;
                        axis_reg   <= AX_ROLL;
                        state_reg  <= S_G0;
                    end
                end
                S_G0:
                begin
                    state_reg <= S_G1;
                end
                S_G1:
                begin
                    pabs_reg    <= pabs_c[30:0];
                    div_neg_reg <= prod_reg[PW-1];
                    skip_reg    <= (axis_reg == AX_YAW) && (pabs_c[30:0] < YAW_MIN);
                    state_reg   <= S_Q0;
                end
                S_Q0:
                begin
                    state_reg <= S_Q1;
                end
                S_Q1:
                begin
                    div_q_reg <= prod_reg[31 +: QB];
                    state_reg <= S_Q2;
                end
                S_Q2:
                begin
                    state_reg <= S_Q3;
                end
                S_Q3:
                begin
                    if (rem_c >= PW'(DIV_D))
                    begin
                        div_q_reg <= div_q_reg + 1'b1;
                    end
                    state_reg <= S_B0;
                end
                S_B0:
                begin
                    state_reg <= S_B1;
                end
                S_B1:
                begin
                    t_reg     <= prod_reg;
                    state_reg <= S_B2;
                end
                S_B2:
                begin
                    case (axis_reg)
                        AX_ROLL:  roll_reg  <= sat_c;
                        AX_PITCH: pitch_reg <= sat_c;
                        default:
                        begin
                            if (!skip_reg)
                            begin
                                yaw_reg <= sat_c;
                            end
                        end
                    endcase
                    if (axis_reg == AX_YAW)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= S_G0;
                    end
                end
                S_DONE:
                begin
                    if (out_load_c)
                    begin
                        m_tdata_reg <= {yaw_reg, pitch_reg, roll_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import imucf_pkg::*;

    localparam int  FRAC      = 16;
    localparam int  WATCHDOG  = 20000;
    localparam int  DRAIN     = 400;
    localparam longint HALF_TURN = 64'sd3019898880;
    localparam longint QUARTER   = 64'sd1509949440;
    localparam longint UNIT_GAIN = 64'sd652032874;
    localparam longint ATAN_TAB [24] = '{
        754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
        15018523, 7509719, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    typedef enum logic [2:0]
    {
        REG_ALPHA,
        REG_STEP_US,
        REG_Z_OFFSET,
        REG_ASA_X,
        REG_ASA_Y,
        REG_ASA_Z,
        REG_UNUSED
    } reg_idx_t;

    typedef struct
    {
        logic signed [15:0] ch [9];
        bit                 mag_ready;
        bit                 mag_overflow;
    } imu_sample_t;

    typedef struct
    {
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
    } attitude_t;

    class attitude_scoreboard;
        longint    gain, step_us, z_offset;
        longint    asa [3];
        longint    roll_q, pitch_q, yaw_q;
        longint    held [3];
        attitude_t pending_q [$];
        int        errors, matched, accepted, yaw_holds;

        function new();
            gain     = 64225;
            step_us  = 1000;
            z_offset = 7000;
            foreach (asa[k]) asa[k] = 128;
            foreach (held[k]) held[k] = 0;
            roll_q = 0; pitch_q = 0; yaw_q = 0;
            errors = 0; matched = 0; accepted = 0; yaw_holds = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_ALPHA:    gain = v[15:0];
                REG_STEP_US:  step_us = v[15:0];
                REG_Z_OFFSET: z_offset = longint'($signed(v[15:0]));
                REG_ASA_X:    asa[0] = v[7:0];
                REG_ASA_Y:    asa[1] = v[7:0];
                REG_ASA_Z:    asa[2] = v[7:0];
                default:      ;
            endcase
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint vec_angle(longint y, longint x);
            longint z, m, nx;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                z = (y >= 0) ? HALF_TURN : -HALF_TURN;
                x = -x;
                y = -y;
            end
            m = mag(x) > mag(y) ? mag(x) : mag(y);
            while (m >= (64'sd1 << 40))
            begin
                x = x >>> 1;
                y = y >>> 1;
                m = mag(x) > mag(y) ? mag(x) : mag(y);
            end
            while (m < (64'sd1 << 39))
            begin
                x = x * 2;
                y = y * 2;
                m = m * 2;
            end
            for (int i = 0; i < 24; i++)
            begin
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + ATAN_TAB[i];
                end
                else
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - ATAN_TAB[i];
                end
                x = nx;
            end
            return z;
        endfunction

        function void rotate(longint a, output longint c, output longint s);
            longint x, y, nx;
            bit     flip;
            x = UNIT_GAIN;
            y = 0;
            flip = 0;
            if (a > QUARTER)
            begin
                a = a - HALF_TURN;
                flip = 1;
            end
            else if (a < -QUARTER)
            begin
                a = a + HALF_TURN;
                flip = 1;
            end
            for (int i = 0; i < 24; i++)
            begin
                if (a >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    a  = a - ATAN_TAB[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    a  = a + ATAN_TAB[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function longint floor_root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        function longint rate_step(longint g);
            return (g * step_us * (64'sd1 << FRAC)) / 64'sd131000000;
        endfunction

        function longint mix(longint gyro_path, longint acc_q24);
            longint t, r;
            t = gain * gyro_path + (65536 - gain) * (acc_q24 >>> (24 - FRAC));
            r = t >>> 16;
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r;
        endfunction

        function void note(imu_sample_t s);
            longint ax, ay, az, gx, gy, gz, rad, roll_a, pitch_a;
            longint cr, sr, cp, sp, hx, hy, hz, myp, mzp, mhx, head;
            attitude_t e;
            accepted++;
            ax = s.ch[0];
            ay = s.ch[1];
            az = longint'(s.ch[2]) - z_offset;
            gx = s.ch[3];
            gy = s.ch[4];
            gz = s.ch[5];
            if (s.mag_ready && !s.mag_overflow)
                for (int k = 0; k < 3; k++)
                    held[k] = s.ch[6 + k];
            roll_a  = vec_angle(ay, az);
            rad     = floor_root(longint'(ay * ay + az * az) << 16);
            pitch_a = vec_angle(-ax * 256, rad);
            rotate(roll_a, cr, sr);
            rotate(pitch_a, cp, sp);
            hx  = held[0] * (asa[0] + 128);
            hy  = held[1] * (asa[1] + 128);
            hz  = held[2] * (asa[2] + 128);
            myp = (hy * cr + hz * sr) >>> 24;
            mzp = (hz * cr - hy * sr) >>> 24;
            mhx = (((hx * 64) * cp) >>> 30) - ((mzp * sp) >>> 30);
            head = vec_angle(-myp, mhx);
            if (mag(gz * step_us) >= 131000)
                yaw_q = mix(yaw_q + rate_step(gz), head);
            else
                yaw_holds++;
            roll_q  = mix(roll_q + rate_step(gx), roll_a);
            pitch_q = mix(pitch_q + rate_step(gy), pitch_a);
            e.roll  = roll_q[31:0];
            e.pitch = pitch_q[31:0];
            e.yaw   = yaw_q[31:0];
            pending_q.push_back(e);
        endfunction

        function void check(logic [95:0] d);
            attitude_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected attitude %h", $time, d);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (d[31:0] !== e.roll)
            begin
                $display("%0t: roll expected %0d actual %0d", $time, e.roll, $signed(d[31:0]));
                errors++;
            end
            if (d[63:32] !== e.pitch)
            begin
                $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                         $signed(d[63:32]));
                errors++;
            end
            if (d[95:64] !== e.yaw)
            begin
                $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, $signed(d[95:64]));
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    attitude_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    int reg_writes;

    imu_complementary_attitude_filter_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check(m_tdata);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        @(posedge clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= 5'(idx * 4);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        sb.write_reg(idx, v);
        reg_writes++;
    endtask

    task automatic send(imu_sample_t s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        for (int k = 0; k < 9; k++)
            s_tdata[16*k +: 16] <= s.ch[k];
        s_tuser <= {s.mag_overflow, s.mag_ready};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note(s);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        do
            @(posedge clk);
        while (sb.pending_q.size() != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic imu_sample_t make_sample(int a, int b, int c, int gx, int gy, int gz,
                                                int mx, int my, int mz, bit rdy, bit ovf);
        imu_sample_t s;
        s.ch = '{16'(a), 16'(b), 16'(c), 16'(gx), 16'(gy), 16'(gz), 16'(mx), 16'(my), 16'(mz)};
        s.mag_ready    = rdy;
        s.mag_overflow = ovf;
        return s;
    endfunction

    function automatic imu_sample_t random_sample();
        imu_sample_t s;
        int pick;
        pick = $urandom_range(9);
        for (int k = 0; k < 9; k++)
            s.ch[k] = 16'($urandom);
        if (pick < 6)
        begin
            // plausible motion: gravity near one g, modest rates, earth-like field
            s.ch[0] = 16'($signed($urandom_range(36000)) - 18000);
            s.ch[1] = 16'($signed($urandom_range(36000)) - 18000);
            s.ch[2] = 16'(sb.z_offset + $signed($urandom_range(36000)) - 18000);
            for (int k = 3; k < 6; k++)
                s.ch[k] = 16'($signed($urandom_range(8000)) - 4000);
            for (int k = 6; k < 9; k++)
                s.ch[k] = 16'($signed($urandom_range(1200)) - 600);
        end
        if ($urandom_range(3) == 0)
            s.ch[5] = 16'($signed($urandom_range(300)) - 150);
        s.mag_ready    = $urandom_range(1);
        s.mag_overflow = ($urandom_range(3) == 0);
        return s;
    endfunction

    task automatic run_random(int count, int idle, int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) send(random_sample());
        drain();
    endtask

    initial
    begin
        imu_sample_t directed [$];
        sb = new();
        rst_n    = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 0;
        psel     = 0;
        penable  = 0;
        pwrite   = 0;
        paddr    = '0;
        pwdata   = '0;
        idle_pct  = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        reg_writes   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        directed.push_back(make_sample(0, 0, 7000, 0, 0, 0, 0, 0, 0, 1, 0));
        directed.push_back(make_sample(0, 0, 23384, 0, 0, 131, 200, -300, 400, 1, 0));
        directed.push_back(make_sample(0, 0, 23384, 0, 0, 130, 900, 900, 900, 1, 1));
        directed.push_back(make_sample(0, 0, 23384, 0, 0, -131, -500, 100, 50, 0, 0));
        directed.push_back(make_sample(32767, 32767, 32767, 32767, 32767, 32767,
                                       32767, 32767, 32767, 1, 0));
        directed.push_back(make_sample(-32768, -32768, -32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768, 1, 0));
        directed.push_back(make_sample(-16384, 0, -9384, 1000, -1000, 5000, 0, 0, 0, 1, 0));
        directed.push_back(make_sample(16384, -100, 7000, 0, 0, -130, 300, 0, -200, 0, 1));
        directed.push_back(make_sample(0, 16384, 7000, 0, 0, 0, -300, -300, 0, 1, 0));
        directed.push_back(make_sample(0, -16384, 7000, 0, 0, 0, 0, 300, 0, 1, 0));
        directed.push_back(make_sample(-1, 0, 6999, -1, 1, -1, 1, -1, 1, 1, 0));
        directed.push_back(make_sample(21845, -21846, 10922, 21845, -21846, 10922,
                                       21845, -21846, 10922, 1, 0));
        directed.push_back(make_sample(-21846, 21845, -10923, -21846, 21845, -10923,
                                       -21846, 21845, -10923, 1, 0));
        foreach (directed[i])
            send(directed[i]);
        drain();

        write_reg(REG_ALPHA, 32'd0);
        write_reg(REG_STEP_US, 32'd1);
        write_reg(REG_Z_OFFSET, 32'hFFFF8000);
        write_reg(REG_ASA_X, 32'd0);
        write_reg(REG_ASA_Y, 32'd255);
        write_reg(REG_ASA_Z, 32'd0);
        write_reg(REG_UNUSED, 32'd12345);
        run_random(150, 0, 0);

        write_reg(REG_ALPHA, 32'd65535);
        write_reg(REG_STEP_US, 32'd65535);
        write_reg(REG_Z_OFFSET, 32'd32767);
        write_reg(REG_ASA_X, 32'd255);
        write_reg(REG_ASA_Y, 32'd0);
        write_reg(REG_ASA_Z, 32'd255);
        run_random(150, 64, 0);

        write_reg(REG_ALPHA, 32'd64225);
        write_reg(REG_STEP_US, 32'd1000);
        write_reg(REG_Z_OFFSET, 32'd7000);
        write_reg(REG_ASA_X, 32'd128);
        write_reg(REG_ASA_Y, 32'd128);
        write_reg(REG_ASA_Z, 32'd128);
        run_random(250, 0, 64);

        write_reg(REG_ALPHA, 32'($urandom_range(65535)));
        write_reg(REG_STEP_US, 32'($urandom_range(65535, 1)));
        write_reg(REG_Z_OFFSET, 32'($urandom));
        write_reg(REG_ASA_X, 32'($urandom_range(255)));
        write_reg(REG_ASA_Y, 32'($urandom_range(255)));
        write_reg(REG_ASA_Z, 32'($urandom_range(255)));
        run_random(250, 11, 11);

        write_reg(REG_ALPHA, 32'd60000);
        write_reg(REG_STEP_US, 32'd5000);
        run_random(200, 0, 0);

        $display("covered %0d samples, %0d attitudes checked, %0d yaw holds, %0d register writes",
                 sb.accepted, sb.matched, sb.yaw_holds, reg_writes);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
src/imucf_pkg.sv
src/imucf_cordic.sv
src/imu_complementary_attitude_filter_core.sv
dv/tb.sv
